// ===== design/alle_pkg.sv =====
// ----------------------------------------------------------------------------
// alle_pkg
// Shared types and constants of the array linked list engine: operation and
// status codes, field widths and default sizes.
// ----------------------------------------------------------------------------
package alle_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int ELEM_WIDTH_DEF = 8;

  localparam int OP_FW    = 2;
  localparam int SLOT_FW  = 6;
  localparam int VALUE_FW = 8;
  localparam int STAT_FW  = 2;

  typedef enum logic [OP_FW-1:0] {
    OP_INS_BEFORE = 2'd0,
    OP_INS_AFTER  = 2'd1,
    OP_REMOVE     = 2'd2,
    OP_FIND       = 2'd3
  } op_e;

  typedef enum logic [STAT_FW-1:0] {
    STAT_OK         = 2'd0,
    STAT_FULL       = 2'd1,
    STAT_NOT_FOUND  = 2'd2,
    STAT_BAD_ANCHOR = 2'd3
  } status_e;

endpackage

// ===== design/alle_ram.sv =====
// ----------------------------------------------------------------------------
// alle_ram
// Generic single-clock RAM with one write port and one read port. The read
// data is registered and holds while no read is enabled.
// ----------------------------------------------------------------------------
module alle_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/array_linked_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// array_linked_list_engine_core
// Cyclic doubly linked list with a free list, kept in three RAMs: element
// plus live bit, next links and prev links. Slot 0 is the sentinel.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that writes the initial links
// and live bits into every slot of the RAMs; in_stall_o is high during it.
// Then each insert or remove reads its anchor's links from the RAMs and
// writes the changed links back. An insert or a remove goes through read,
// first write, second write and result. An insert or remove with an invalid
// anchor, or an insert into a full list, goes from the read straight to the
// result. A find scans the element RAM one slot per cycle from slot 1 and
// stops at the first live slot that matches, or at the last slot with a
// not-found status. One transaction is worked on at a time; a finished
// result sits in the output register, and the next transaction is accepted
// while it waits.
// ----------------------------------------------------------------------------
module array_linked_list_engine_core #(
  parameter int CAPACITY   = alle_pkg::CAPACITY_DEF,
  parameter int ELEM_WIDTH = alle_pkg::ELEM_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [alle_pkg::OP_FW-1:0]    opcode_i,
  input  logic [alle_pkg::SLOT_FW-1:0]  anchor_slot_i,
  input  logic [alle_pkg::VALUE_FW-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [alle_pkg::SLOT_FW-1:0]  slot_index_o,
  output logic [alle_pkg::STAT_FW-1:0]  status_o
);

  localparam int SW = $clog2(CAPACITY);
  localparam int EW = ELEM_WIDTH;
  localparam int NW = ELEM_WIDTH + 1;
  localparam int AW = (SW > alle_pkg::SLOT_FW) ? SW : alle_pkg::SLOT_FW;
  localparam int VW = (EW > alle_pkg::VALUE_FW) ? EW : alle_pkg::VALUE_FW;
  localparam logic [SW-1:0] LAST_SLOT = SW'(CAPACITY - 1);
  localparam logic [SW-1:0] FIRST_SLOT = SW'(1);
  localparam logic [SW-1:0] SECOND_SLOT = SW'(2);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_LOOK  = 6'b000100,
    ST_LINK  = 6'b001000,
    ST_SCAN  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [SW-1:0]     clr_q, clr_d;
  logic [SW-1:0]     fh_q, fh_d;
  logic [SW-1:0]     nfh_q, nfh_d;
  logic              pf_q, pf_d;
  alle_pkg::op_e     op_q, op_d;
  logic [SW-1:0]     anc_q, anc_d;
  logic              inr_q, inr_d;
  logic [EW-1:0]     val_q, val_d;
  logic [SW-1:0]     slot_q, slot_d;
  logic [SW-1:0]     before_q, before_d;
  logic [SW-1:0]     after_q, after_d;
  logic [SW-1:0]     scan_q, scan_d;
  logic [SW-1:0]     res_slot_q, res_slot_d;
  alle_pkg::status_e res_stat_q, res_stat_d;
  logic              out_valid_q, out_valid_d;
  logic [SW-1:0]     out_slot_q, out_slot_d;
  alle_pkg::status_e out_stat_q, out_stat_d;

  logic [AW-1:0]     anc_ext;
  logic [SW-1:0]     anc_in;
  logic              anc_inr;
  logic [VW-1:0]     val_ext;
  logic [AW-1:0]     out_slot_ext;
  logic              load_out;
  logic              node_live;

  logic          node_we, node_re;
  logic [SW-1:0] node_waddr, node_raddr;
  logic [NW-1:0] node_wdata, node_rdata;
  logic          next_we, next_re;
  logic [SW-1:0] next_waddr, next_raddr, next_wdata, next_rdata;
  logic          prev_we, prev_re;
  logic [SW-1:0] prev_waddr, prev_raddr, prev_wdata, prev_rdata;

  alle_ram #(.Width(NW), .Depth(CAPACITY)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .re_i    (node_re),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  alle_ram #(.Width(SW), .Depth(CAPACITY)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .re_i    (next_re),
    .raddr_i (next_raddr),
    .rdata_o (next_rdata)
  );

  alle_ram #(.Width(SW), .Depth(CAPACITY)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .re_i    (prev_re),
    .raddr_i (prev_raddr),
    .rdata_o (prev_rdata)
  );

  assign anc_ext   = AW'(anchor_slot_i);
  assign anc_in    = anc_ext[SW-1:0];
  assign anc_inr   = (32'(anchor_slot_i) < 32'(CAPACITY));
  assign val_ext   = VW'(value_i);
  assign node_live = node_rdata[NW-1];
  assign load_out  = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    fh_d       = fh_q;
    nfh_d      = pf_q ? next_rdata : nfh_q;
    pf_d       = 1'b0;
    op_d       = op_q;
    anc_d      = anc_q;
    inr_d      = inr_q;
    val_d      = val_q;
    slot_d     = slot_q;
    before_d   = before_q;
    after_d    = after_q;
    scan_d     = scan_q;
    res_slot_d = res_slot_q;
    res_stat_d = res_stat_q;

    node_we    = 1'b0;
    node_waddr = anc_q;
    node_wdata = {1'b0, val_q};
    node_re    = 1'b0;
    node_raddr = anc_in;
    next_we    = 1'b0;
    next_waddr = anc_q;
    next_wdata = '0;
    next_re    = 1'b0;
    next_raddr = anc_in;
    prev_we    = 1'b0;
    prev_waddr = anc_q;
    prev_wdata = '0;
    prev_re    = 1'b0;
    prev_raddr = anc_in;

    case (state_q)
      ST_CLEAR: begin
        node_we    = 1'b1;
        node_waddr = clr_q;
        node_wdata = {(clr_q == '0), EW'(0)};
        next_we    = 1'b1;
        next_waddr = clr_q;
        next_wdata = (clr_q == '0 || clr_q == LAST_SLOT) ? '0 : clr_q + 1'b1;
        prev_we    = 1'b1;
        prev_waddr = clr_q;
        prev_wdata = (clr_q == '0) ? '0 : clr_q - 1'b1;
        clr_d      = clr_q + 1'b1;
        if (clr_q == LAST_SLOT) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d  = alle_pkg::op_e'(opcode_i);
          anc_d = anc_in;
          inr_d = anc_inr;
          val_d = val_ext[EW-1:0];
          if (alle_pkg::op_e'(opcode_i) == alle_pkg::OP_FIND) begin
            node_re    = 1'b1;
            node_raddr = FIRST_SLOT;
            scan_d     = FIRST_SLOT;
            state_d    = ST_SCAN;
          end else begin
            node_re = 1'b1;
            next_re = 1'b1;
            prev_re = 1'b1;
            state_d = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        res_slot_d = '0;
        if (op_q == alle_pkg::OP_REMOVE) begin
          if (anc_q == '0 || !inr_q || !node_live) begin
            res_stat_d = alle_pkg::STAT_BAD_ANCHOR;
            state_d    = ST_DONE;
          end else begin
            next_we    = 1'b1;
            next_waddr = prev_rdata;
            next_wdata = next_rdata;
            prev_we    = 1'b1;
            prev_waddr = next_rdata;
            prev_wdata = prev_rdata;
            node_we    = 1'b1;
            node_waddr = anc_q;
            node_wdata = {1'b0, val_q};
            state_d    = ST_LINK;
          end
        end else begin
          if (!inr_q || !node_live) begin
            res_stat_d = alle_pkg::STAT_BAD_ANCHOR;
            state_d    = ST_DONE;
          end else if (fh_q == '0) begin
            res_stat_d = alle_pkg::STAT_FULL;
            state_d    = ST_DONE;
          end else begin
            if (op_q == alle_pkg::OP_INS_AFTER) begin
              before_d = anc_q;
              after_d  = next_rdata;
            end else begin
              before_d = prev_rdata;
              after_d  = anc_q;
            end
            node_we    = 1'b1;
            node_waddr = fh_q;
            node_wdata = {1'b1, val_q};
            next_we    = 1'b1;
            next_waddr = fh_q;
            next_wdata = after_d;
            prev_we    = 1'b1;
            prev_waddr = fh_q;
            prev_wdata = before_d;
            slot_d     = fh_q;
            fh_d       = nfh_q;
            state_d    = ST_LINK;
          end
        end
      end
      ST_LINK: begin
        res_stat_d = alle_pkg::STAT_OK;
        if (op_q == alle_pkg::OP_REMOVE) begin
          next_we    = 1'b1;
          next_waddr = anc_q;
          next_wdata = fh_q;
          prev_we    = 1'b1;
          prev_waddr = anc_q;
          prev_wdata = '0;
          fh_d       = anc_q;
          nfh_d      = fh_q;
          res_slot_d = '0;
        end else begin
          next_we    = 1'b1;
          next_waddr = before_q;
          next_wdata = slot_q;
          prev_we    = 1'b1;
          prev_waddr = after_q;
          prev_wdata = slot_q;
          // prefetch the link behind the new free head
          next_re    = 1'b1;
          next_raddr = fh_q;
          pf_d       = 1'b1;
          res_slot_d = slot_q;
        end
        state_d = ST_DONE;
      end
      ST_SCAN: begin
        if (node_live && node_rdata[EW-1:0] == val_q) begin
          res_slot_d = scan_q;
          res_stat_d = alle_pkg::STAT_OK;
          state_d    = ST_DONE;
        end else if (scan_q == LAST_SLOT) begin
          res_slot_d = '0;
          res_stat_d = alle_pkg::STAT_NOT_FOUND;
          state_d    = ST_DONE;
        end else begin
          node_re    = 1'b1;
          node_raddr = scan_q + 1'b1;
          scan_d     = scan_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_slot_d  = out_slot_q;
    out_stat_d  = out_stat_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_slot_d  = res_slot_q;
      out_stat_d  = res_stat_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      fh_q        <= FIRST_SLOT;
      nfh_q       <= SECOND_SLOT;
      pf_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      fh_q        <= fh_d;
      nfh_q       <= nfh_d;
      pf_q        <= pf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    anc_q      <= anc_d;
    inr_q      <= inr_d;
    val_q      <= val_d;
    slot_q     <= slot_d;
    before_q   <= before_d;
    after_q    <= after_d;
    scan_q     <= scan_d;
    res_slot_q <= res_slot_d;
    res_stat_q <= res_stat_d;
    out_slot_q <= out_slot_d;
    out_stat_q <= out_stat_d;
  end

  assign out_slot_ext = AW'(out_slot_q);
  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign slot_index_o = out_slot_ext[alle_pkg::SLOT_FW-1:0];
  assign status_o     = out_stat_q;

endmodule
